// ===== hw/rtl/dq_pkg.sv =====
package dq_pkg;

  // Fixed field widths of the stream beats
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  // Operation codes carried in the input tuser
  typedef enum logic [KIND_W-1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_REAR  = 2'd1,
    OP_REM_FRONT = 2'd2,
    OP_REM_REAR  = 2'd3
  } op_e;

  // Result status carried in the output tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  // Per-operation outcome handed from the pointer logic to the result stage
  typedef struct packed {
    logic             rd_used;
    status_e          status;
    logic [OCC_W-1:0] occ;
  } dq_info_t;

endpackage

// ===== hw/rtl/double_ended_queue_core.sv =====
// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   tuser: kind[1:0]; tdata: value[31:0]
// m_axis    out  tuser: status[1:0]; tdata: removed_value[31:0], occupancy[36:32]
//
// In the accept cycle the head and count update and at most one memory access is
// issued; in the next cycle the output register loads from the registered read of
// the word store.
// No new beat is taken while a result is pending or while the previous result waits
// on m_axis with m_axis_tready low, so no operation starts before the last is output.
// Reset clears head and count (queue empty); the word store is not cleared.
module double_ended_queue_core import dq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // value[31:0]
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // removed_value[31:0], occupancy[36:32], zero fill
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              accept;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [WORD_W-1:0] rd_data;
  dq_info_t          info;
  dq_info_t          pend_info_q;
  logic              pend_q;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_word_q;
  status_e           out_status_q;
  logic [OCC_W-1:0]  out_occ_q;

  // Take a beat when no result is in flight and the output frees up
  assign s_axis_tready = !pend_q && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  dq_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .op_i      (op_e'(s_axis_tuser)),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .info_o    (info)
  );

  dq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Hold the outcome while the read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_info_q <= info;
    end
  end

  // Output register: load on a pending result, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (pend_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      out_word_q   <= pend_info_q.rd_used ? rd_data : '0;
      out_status_q <= pend_info_q.status;
      out_occ_q    <= pend_info_q.occ;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_occ_q, out_word_q};
  assign m_axis_tuser  = out_status_q;

  // A pending result always finds the output register empty
  a_pend_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !out_valid_q)
    else $error("pending result collides with a held output beat");

  // Every accepted beat is pending in the next cycle and then shows up as a valid result
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (pend_q ##1 m_axis_tvalid))
    else $error("accepted beat did not reach the output");

  // Failed operations return a zero word
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ST_UNDERFLOW || m_axis_tuser == ST_OVERFLOW))
      |-> (m_axis_tdata[31:0] == '0))
    else $error("failed operation returned a nonzero word");

  // No read and write issued in the same cycle
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("memory read and write issued together");

endmodule

// ===== hw/rtl/dq_ram.sv =====
module dq_ram import dq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [WORD_W-1:0] rd_data_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/dq_ctrl.sv =====
module dq_ctrl import dq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  op_e               op_i,
  output logic              wr_en_o,
  output logic [AW-1:0]     wr_addr_o,
  output logic              rd_en_o,
  output logic [AW-1:0]     rd_addr_o,
  output dq_info_t          info_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [SW-1:0] tail_sum, rear_sum;
  logic [AW-1:0] tail_idx, rear_idx, head_dec, head_inc;
  logic          is_full, is_empty;

  // Slot after the rear and the rear slot, wrapped once around the ring; head stepped back and on
  always_comb begin
    tail_sum = SW'(head_q) + SW'(count_q);
    rear_sum = tail_sum - SW'(1);
    tail_idx = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
    rear_idx = (rear_sum >= DEPTH_S) ? AW'(rear_sum - DEPTH_S) : AW'(rear_sum);
    head_dec = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
    head_inc = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
  end

  assign is_full  = (count_q == CW'(DEPTH));
  assign is_empty = (count_q == '0);

  // Decode the operation into memory accesses and the new pointers
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = tail_idx;
    rd_en_o     = 1'b0;
    rd_addr_o   = rear_idx;
    info_o      = '{rd_used: 1'b0, status: ST_DONE, occ: '0};
    case (op_i)
      OP_INS_FRONT: begin
        if (is_full) begin
          info_o.status = ST_OVERFLOW;
        end else begin
          head_d    = head_dec;
          count_d   = count_q + CW'(1);
          wr_en_o   = accept_i;
          wr_addr_o = head_dec;
        end
      end
      OP_INS_REAR: begin
        if (is_full) begin
          info_o.status = ST_OVERFLOW;
        end else begin
          count_d   = count_q + CW'(1);
          wr_en_o   = accept_i;
          wr_addr_o = tail_idx;
        end
      end
      OP_REM_FRONT: begin
        if (is_empty) begin
          info_o.status = ST_UNDERFLOW;
        end else begin
          head_d         = head_inc;
          count_d        = count_q - CW'(1);
          rd_en_o        = accept_i;
          rd_addr_o      = head_q;
          info_o.rd_used = 1'b1;
        end
      end
      OP_REM_REAR: begin
        if (is_empty) begin
          info_o.status = ST_UNDERFLOW;
        end else begin
          count_d        = count_q - CW'(1);
          rd_en_o        = accept_i;
          rd_addr_o      = rear_idx;
          info_o.rd_used = 1'b1;
        end
      end
      default: begin
        info_o.status = ST_DONE;
      end
    endcase
    info_o.occ = OCC_W'(count_d);
  end

  // Pointer registers advance only on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import dq_pkg::*;

  localparam int unsigned DQ_DEPTH = 16;
  localparam int unsigned RAND_ITEMS = 924;
  localparam int unsigned CALM_ITEMS = 100;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;

  // One operation outcome as seen on the result channel
  typedef struct packed {
    logic [31:0] removed;
    status_e     status;
    logic [4:0]  occ;
  } dq_result_t;

  // One row of the directed stimulus table
  typedef struct {
    op_e         kind;
    logic [31:0] value;
    bit          typed;
    dq_result_t  exp;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;  // value[31:0]
  logic [1:0]  s_axis_tuser;  // kind[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;  // removed_value[31:0], occupancy[36:32], zero fill
  logic [1:0]  m_axis_tuser;  // status[1:0]

  // Shadow deque state
  logic [31:0] shadow_words [DQ_DEPTH];
  logic [3:0]  shadow_head;
  logic [4:0]  shadow_count;

  dq_result_t  pending_results[$];
  stim_row_t   dir_rows[$];
  bit          drv_typed;
  dq_result_t  drv_exp;
  bit          calm;
  int unsigned gap_pct;
  int unsigned err_count;
  int unsigned idle_cycles;

  double_ended_queue_core #(.DEPTH(DQ_DEPTH)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Apply one operation to the shadow deque and return its outcome
  function automatic dq_result_t deque_apply(op_e kind, logic [31:0] value);
    dq_result_t res;
    res.removed = '0;
    res.status  = ST_DONE;
    case (kind)
      OP_INS_FRONT, OP_INS_REAR: begin
        if (shadow_count >= DQ_DEPTH) begin
          res.status = ST_OVERFLOW;
        end else if (kind == OP_INS_FRONT) begin
          shadow_head = shadow_head - 4'd1;
          shadow_words[shadow_head] = value;
          shadow_count = shadow_count + 5'd1;
        end else begin
          shadow_words[4'(shadow_head + shadow_count[3:0])] = value;
          shadow_count = shadow_count + 5'd1;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          res.status = ST_UNDERFLOW;
        end else if (kind == OP_REM_FRONT) begin
          res.removed = shadow_words[shadow_head];
          shadow_head = shadow_head + 4'd1;
          shadow_count = shadow_count - 5'd1;
        end else begin
          res.removed = shadow_words[4'(shadow_head + shadow_count[3:0] - 4'd1)];
          shadow_count = shadow_count - 5'd1;
        end
      end
    endcase
    res.occ = shadow_count;
    return res;
  endfunction

  function automatic void add_row(op_e kind, logic [31:0] value, bit typed,
                                  logic [31:0] rm, status_e st, logic [4:0] oc);
    stim_row_t row;
    row.kind        = kind;
    row.value       = value;
    row.typed       = typed;
    row.exp.removed = rm;
    row.exp.status  = st;
    row.exp.occ     = oc;
    dir_rows.push_back(row);
  endfunction

  // Present one beat, with an optional idle burst first, and hold until taken
  task automatic send_beat(op_e kind, logic [31:0] value, bit typed, dq_result_t exp);
    int unsigned gap;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser  = kind;
    s_axis_tdata  = value;
    drv_typed     = typed;
    drv_exp       = exp;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Check result beats, queue expectations for taken input beats, guard progress
  always @(posedge clk_i) begin : monitor
    dq_result_t got;
    dq_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.removed = m_axis_tdata[31:0];
        got.occ     = m_axis_tdata[36:32];
        got.status  = status_e'(m_axis_tuser);
        if (pending_results.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("ERROR: unexpected result beat removed=%h status=%0d occ=%0d",
                     got.removed, got.status, got.occ);
        end else begin
          want = pending_results.pop_front();
          if (got.removed !== want.removed || got.status !== want.status ||
              got.occ !== want.occ) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("ERROR: removed exp %h got %h, status exp %0d got %0d, occ exp %0d got %0d",
                       want.removed, got.removed, want.status, got.status,
                       want.occ, got.occ);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = deque_apply(op_e'(s_axis_tuser), s_axis_tdata);
        if (drv_typed) want = drv_exp;
        pending_results.push_back(want);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Result side: stall bursts mixed with ready runs, always ready near the end
  initial begin : sink
    int unsigned stall_left;
    int unsigned run_left;
    stall_left = 0;
    run_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && run_left == 0) begin
        if ($urandom_range(0, 3) == 0)
          stall_left = $urandom_range(1, 14);
        else
          run_left = $urandom_range(1, 40);
      end
      if (calm || stall_left == 0) begin
        m_axis_tready = 1'b1;
        if (run_left > 0) run_left--;
      end else begin
        m_axis_tready = 1'b0;
        stall_left--;
      end
    end
  end

  initial begin : stimulus
    dq_result_t  none;
    op_e         kind;
    logic [31:0] value;
    int unsigned ins_pct;
    int unsigned sel;

    none = '0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_INS_FRONT;
    drv_typed = 1'b0;
    drv_exp = '0;
    calm = 1'b0;
    gap_pct = 20;
    err_count = 0;
    idle_cycles = 0;
    ins_pct = 50;
    shadow_head = '0;
    shadow_count = '0;
    foreach (shadow_words[i]) shadow_words[i] = '0;

    // Directed table: empty removals, extremes, last-element removals, fill, overflow
    add_row(OP_REM_FRONT, 32'h0000_0000, 1, 32'h0, ST_UNDERFLOW, 5'd0);
    add_row(OP_REM_REAR,  32'hFFFF_FFFF, 1, 32'h0, ST_UNDERFLOW, 5'd0);
    add_row(OP_INS_FRONT, 32'h8000_0000, 1, 32'h0, ST_DONE, 5'd1);
    add_row(OP_INS_REAR,  32'h7FFF_FFFF, 1, 32'h0, ST_DONE, 5'd2);
    add_row(OP_REM_FRONT, 32'h0000_0000, 1, 32'h8000_0000, ST_DONE, 5'd1);
    add_row(OP_REM_REAR,  32'h0000_0000, 1, 32'h7FFF_FFFF, ST_DONE, 5'd0);
    add_row(OP_INS_REAR,  32'hFFFF_FFFF, 1, 32'h0, ST_DONE, 5'd1);
    add_row(OP_REM_FRONT, 32'h0000_0000, 1, 32'hFFFF_FFFF, ST_DONE, 5'd0);
    for (int i = 0; i < DQ_DEPTH; i++)
      add_row(i[0] ? OP_INS_REAR : OP_INS_FRONT,
              32'h1357_9BDF ^ (i * 32'h1111_1111), 0, 32'h0, ST_DONE, 5'd0);
    add_row(OP_INS_FRONT, 32'h0000_0000, 1, 32'h0, ST_OVERFLOW, 5'd16);
    add_row(OP_INS_REAR,  32'hFFFF_FFFF, 1, 32'h0, ST_OVERFLOW, 5'd16);

    // Hold reset, then release it away from the clock edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].exp);

    // Random part: phases that grow, drain or churn the deque
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 32 == 0) begin
        sel = $urandom_range(0, 2);
        ins_pct = (sel == 0) ? 80 : (sel == 1) ? 20 : 50;
      end
      if (n % 50 == 0) begin
        sel = $urandom_range(0, 2);
        gap_pct = (sel == 0) ? 0 : (sel == 1) ? 10 : 35;
      end
      if (n >= RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      if ($urandom_range(0, 99) < ins_pct)
        kind = $urandom_range(0, 1) ? OP_INS_REAR : OP_INS_FRONT;
      else
        kind = $urandom_range(0, 1) ? OP_REM_REAR : OP_REM_FRONT;
      case ($urandom_range(0, 15))
        0:       value = 32'h0000_0000;
        1:       value = 32'hFFFF_FFFF;
        2:       value = 32'h8000_0000;
        3:       value = 32'h7FFF_FFFF;
        default: value = $urandom;
      endcase
      send_beat(kind, value, 1'b0, none);
    end
    s_axis_tvalid = 1'b0;

    // Drain outstanding results, then keep watching for stray beats before the verdict
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dq_pkg.sv
hw/rtl/dq_ram.sv
hw/rtl/dq_ctrl.sv
hw/rtl/double_ended_queue_core.sv
verif/tb.sv
